// ===== design/brf_pkg.sv =====
// Package for the circular byte FIFO: sizes, input codes and the
// controller/datapath command and status types. No dependencies.
`default_nettype none

package brf_pkg;

    // Store geometry
    localparam int DEPTH     = 256;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // Burst limit and item field widths
    localparam int MAX_BURST = 64;
    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int REQ_W     = 7;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BURST = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_CLEAR,
        OP_EMPTY
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              last;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] held;
        logic             slot_free;
    } status_t;

endpackage

`default_nettype wire

// ===== design/brf_channels.sv =====
// Valid/ready channel interfaces for the circular byte FIFO.
// Depends on brf_pkg for field widths.
`default_nettype none

interface brf_item_if;
    logic                          valid;
    logic                          ready;
    logic [brf_pkg::KIND_W-1:0]    kind;
    logic [brf_pkg::BYTE_W-1:0]    data_byte;
    logic [brf_pkg::REQ_W-1:0]     pop_count;

    modport source (output valid, kind, data_byte, pop_count, input ready);
    modport sink   (input valid, kind, data_byte, pop_count, output ready);
endinterface

interface brf_result_if;
    logic                          valid;
    logic                          ready;
    logic [brf_pkg::BYTE_W-1:0]    out_byte;
    logic                          has_data;
    logic                          dropped;
    logic                          last;
    logic [brf_pkg::CNT_W-1:0]     fill_count;
    logic [brf_pkg::CNT_W-1:0]     free_count;

    modport source (output valid, out_byte, has_data, dropped, last, fill_count,
                    free_count, input ready);
    modport sink   (input valid, out_byte, has_data, dropped, last, fill_count,
                    free_count, output ready);
endinterface

`default_nettype wire

// ===== design/brf_ctrl.sv =====
// Controller of the circular byte FIFO: decodes items and sequences bursts.
// Depends on brf_pkg and brf_item_if.
`default_nettype none

module brf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    brf_item_if.sink              item,
    input  wire brf_pkg::status_t status,
    output brf_pkg::cmd_t         cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } state_t;

    state_t                         state_reg, state_next;
    logic [brf_pkg::REQ_W-1:0]      remain_reg, remain_next;
    logic [brf_pkg::REQ_W-1:0]      req_sat;
    logic [brf_pkg::REQ_W-1:0]      burst_len;
    logic                           accept;

    // Clamp the request to the burst limit, then to what the queue holds
    always_comb
    begin
        if (item.pop_count > brf_pkg::REQ_W'(brf_pkg::MAX_BURST))
            req_sat = brf_pkg::REQ_W'(brf_pkg::MAX_BURST);
        else
            req_sat = item.pop_count;
        if (brf_pkg::CNT_W'(req_sat) > status.held)
            burst_len = status.held[brf_pkg::REQ_W-1:0];
        else
            burst_len = req_sat;
    end

    assign item.ready = (state_reg == ST_IDLE) && status.slot_free;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        state_next  = state_reg;
        remain_next = remain_reg;
        cmd.op      = brf_pkg::OP_NONE;
        cmd.last    = 1'b1;
        cmd.data    = item.data_byte;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.kind)
                        brf_pkg::KIND_PUSH:  cmd.op = brf_pkg::OP_PUSH;
                        brf_pkg::KIND_POP:   cmd.op = brf_pkg::OP_POP;
                        brf_pkg::KIND_CLEAR: cmd.op = brf_pkg::OP_CLEAR;
                        brf_pkg::KIND_BURST:
                        begin
                            if (burst_len == '0)
                                cmd.op = brf_pkg::OP_EMPTY;
                            else
                            begin
                                cmd.op = brf_pkg::OP_POP;
                                if (burst_len != brf_pkg::REQ_W'(1))
                                begin
                                    cmd.last    = 1'b0;
                                    remain_next = burst_len - brf_pkg::REQ_W'(1);
                                    state_next  = ST_BURST;
                                end
                            end
                        end
                        default: cmd.op = brf_pkg::OP_NONE;
                    endcase
                end
            end
            ST_BURST:
            begin
                // One byte per free output slot; finish on the last one
                if (status.slot_free)
                begin
                    cmd.op      = brf_pkg::OP_POP;
                    cmd.last    = (remain_reg == brf_pkg::REQ_W'(1));
                    remain_next = remain_reg - brf_pkg::REQ_W'(1);
                    if (remain_reg == brf_pkg::REQ_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

    a_burst_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BURST) |-> (remain_reg != '0))
        else $error("burst state with nothing left to emit");

    a_burst_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BURST) |-> !item.ready)
        else $error("input taken during a burst");

    a_burst_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.kind == brf_pkg::KIND_BURST) && (burst_len > brf_pkg::REQ_W'(1)))
        |=> (state_reg == ST_BURST))
        else $error("multi-byte burst did not start sequencing");

endmodule

`default_nettype wire

// ===== design/brf_datapath.sv =====
// Datapath of the circular byte FIFO: byte store, pointers, fill count,
// capacity register and the result register. Depends on brf_pkg, brf_result_if.
`default_nettype none

module brf_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [brf_pkg::CNT_W-1:0]  cfg_wdata,
    input  wire brf_pkg::cmd_t              cmd,
    output brf_pkg::status_t                status,
    brf_result_if.source                    result
);

    logic [brf_pkg::BYTE_W-1:0] mem [brf_pkg::DEPTH];

    logic [brf_pkg::CNT_W-1:0]  cap_reg, cap_next;
    logic [brf_pkg::PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [brf_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [brf_pkg::CNT_W-1:0]  held_reg, held_next;
    logic                       out_valid_reg, out_valid_next;

    logic [brf_pkg::BYTE_W-1:0] out_byte_reg;
    logic                       has_data_reg, dropped_reg, last_reg;
    logic [brf_pkg::CNT_W-1:0]  fill_reg, free_reg;

    logic                       load;
    logic                       full, empty;
    logic                       wr_en, rd_en;
    logic [brf_pkg::CNT_W-1:0]  wr_inc, rd_inc;

    assign load   = (cmd.op != brf_pkg::OP_NONE);
    assign full   = (held_reg >= cap_reg);
    assign empty  = (held_reg == '0);
    assign wr_en  = (cmd.op == brf_pkg::OP_PUSH) && !full;
    assign rd_en  = (cmd.op == brf_pkg::OP_POP) && !empty;
    assign wr_inc = brf_pkg::CNT_W'(wr_ptr_reg) + brf_pkg::CNT_W'(1);
    assign rd_inc = brf_pkg::CNT_W'(rd_ptr_reg) + brf_pkg::CNT_W'(1);

    assign status.held      = held_reg;
    assign status.slot_free = !out_valid_reg || result.ready;

    always_comb
    begin
        cap_next       = cap_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (load)
            out_valid_next = 1'b1;
        if (cfg_we)
        begin
            // Map out-of-range capacity into 1..DEPTH; emptying the queue
            if (cfg_wdata == '0)
                cap_next = brf_pkg::CNT_W'(1);
            else if (cfg_wdata > brf_pkg::CNT_W'(brf_pkg::DEPTH))
                cap_next = brf_pkg::CNT_W'(brf_pkg::DEPTH);
            else
                cap_next = cfg_wdata;
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            held_next   = '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_next = (wr_inc >= cap_reg) ? '0 : wr_inc[brf_pkg::PTR_W-1:0];
                held_next   = held_reg + brf_pkg::CNT_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_next = (rd_inc >= cap_reg) ? '0 : rd_inc[brf_pkg::PTR_W-1:0];
                held_next   = held_reg - brf_pkg::CNT_W'(1);
            end
            if (cmd.op == brf_pkg::OP_CLEAR)
            begin
                wr_ptr_next = '0;
                rd_ptr_next = '0;
                held_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= brf_pkg::CNT_W'(brf_pkg::DEPTH);
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Byte store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= cmd.data;
        if (rd_en)
            out_byte_reg <= mem[rd_ptr_reg];
        else if (load)
            out_byte_reg <= '0;
    end

    // Result fields; counts are taken after this result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            has_data_reg <= rd_en;
            dropped_reg  <= (cmd.op == brf_pkg::OP_PUSH) && full;
            last_reg     <= cmd.last;
            fill_reg     <= held_next;
            free_reg     <= cap_reg - held_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_byte   = out_byte_reg;
    assign result.has_data   = has_data_reg;
    assign result.dropped    = dropped_reg;
    assign result.last       = last_reg;
    assign result.fill_count = fill_reg;
    assign result.free_count = free_reg;

    a_held_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= cap_reg)
        else $error("fill count above capacity");

    a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
        ((brf_pkg::CNT_W + 1)'(fill_reg) + (brf_pkg::CNT_W + 1)'(free_reg)
         == (brf_pkg::CNT_W + 1)'(cap_reg)))
        else $error("fill and free counts disagree with capacity");

    a_ptr_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (brf_pkg::CNT_W'(wr_ptr_reg) < cap_reg) && (brf_pkg::CNT_W'(rd_ptr_reg) < cap_reg))
        else $error("pointer beyond capacity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> !$changed(out_byte_reg) || $past(cfg_we))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== design/byte_ring_fifo_core.sv =====
// Top level of the circular byte FIFO with run-time capacity.
// Depends on brf_pkg, brf_channels (interfaces), brf_ctrl and brf_datapath.
`default_nettype none

// Circular byte FIFO of up to 256 slots. Each item on the item channel is a
// push (kind 0), a pop (kind 1), a burst pop of up to 64 bytes (kind 2) or a
// clear (kind 3); every result on the result channel carries the fill and
// free counts left after it. Push, pop, clear and an empty burst each give
// one result; a burst of n bytes gives n results, one byte per cycle while
// the result slot is free, since the byte store has a single read port.
// Results appear in the cycle after acceptance from a result register, and a
// new item is taken in the same cycle the previous result leaves, so single
// pushes and pops run one per cycle when the result side keeps ready high. A
// full queue drops a push and flags it; a pop from an empty queue answers 0
// with has_data low. The capacity register (cfg_we / cfg_wdata) resets to
// 256; 0 acts as 1 and values above 256 act as 256. Writing it empties the
// queue, so write it only while the block is idle.
module byte_ring_fifo_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    brf_item_if.sink                        item,
    brf_result_if.source                    result,
    input  wire logic                       cfg_we,
    input  wire logic [brf_pkg::CNT_W-1:0]  cfg_wdata
);

    brf_pkg::cmd_t    cmd;
    brf_pkg::status_t status;

    // Decode items, sequence bursts
    brf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .status (status),
        .cmd    (cmd)
    );

    // Hold the store, pointers, capacity and the result register
    brf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

`default_nettype wire
